// ===== design/thd_pkg.sv =====
// thd_pkg: widths, constants, the arctangent table and shared types of the heading pipeline
// no dependencies; used by every module of tilt_compensated_heading and by its checker

package thd_pkg;

    // sensor and cross product widths
    localparam int InW    = 16;
    localparam int ProdW  = 2 * InW;
    localparam int CrossW = ProdW + 1;

    // normalization: the larger magnitude is shifted up until its top one sits at bit 56
    localparam int MagW   = 57;
    localparam int NormW  = MagW + 1;

    // rotation datapath: gain and the half-plane fold need three extra bits of headroom
    localparam int CordW  = NormW + 3;
    localparam int Steps  = 32;

    // angle in nanodegrees, |z| stays below 2^39
    localparam int AngW   = 40;
    localparam int TabW   = 36;

    // output scaling: n / 1e7 = (n >> 7) / 78125, done as a reciprocal multiply
    localparam int ScaleDrop = 7;
    localparam int QuoInW    = 32;
    localparam int ProdOutW  = 2 * QuoInW;
    localparam int RecipSh   = 48;
    localparam int HeadW     = 16;

    localparam logic signed [AngW-1:0] HalfTurnNd = 40'sd180000000000;
    localparam logic [AngW-1:0]        WrapRound  = 40'd360005000000;
    localparam logic [AngW-1:0]        RoundOnly  = 40'd5000000;
    localparam logic [QuoInW-1:0]      RecipM     = 32'd3602879702;
    localparam logic [HeadW-1:0]       FullTurnCd = 16'd36000;

    // cycles from an accepted transaction to its result strobe
    localparam int Latency = 41;

    // control that travels with every stage
    typedef struct packed {
        logic vld;
        logic zero;
    } t_ctl;

    // atan(2^-idx) in nanodegrees, rounded to nearest
    function automatic logic [TabW-1:0] atan_nd(input int unsigned idx);
        logic [63:0] v;
        case (idx)
            0:       v = 64'd45000000000;
            1:       v = 64'd26565051177;
            2:       v = 64'd14036243468;
            3:       v = 64'd7125016349;
            4:       v = 64'd3576334375;
            5:       v = 64'd1789910608;
            6:       v = 64'd895173710;
            7:       v = 64'd447614171;
            8:       v = 64'd223810500;
            9:       v = 64'd111905677;
            10:      v = 64'd55952892;
            11:      v = 64'd27976453;
            12:      v = 64'd13988227;
            13:      v = 64'd6994114;
            14:      v = 64'd3497057;
            15:      v = 64'd1748528;
            16:      v = 64'd874264;
            default: v = (64'd57295779513 + (64'd1 << (idx - 1))) >> idx;
        endcase
        return v[TabW-1:0];
    endfunction

endpackage

// ===== design/thd_front.sv =====
// thd_front: two stages that form the horizontal field components xh and yh
// depends on thd_pkg

module thd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [thd_pkg::InW-1:0]      i_mag_x,
    input  logic signed [thd_pkg::InW-1:0]      i_mag_y,
    input  logic signed [thd_pkg::InW-1:0]      i_mag_z,
    input  logic signed [thd_pkg::InW-1:0]      i_acc_x,
    input  logic signed [thd_pkg::InW-1:0]      i_acc_y,
    input  logic signed [thd_pkg::InW-1:0]      i_acc_z,
    output logic                                o_vld,
    output logic signed [thd_pkg::CrossW-1:0]   o_xh,
    output logic signed [thd_pkg::CrossW-1:0]   o_yh
);

    logic                              r_p_vld;
    logic signed [thd_pkg::ProdW-1:0]  r_mx_az;
    logic signed [thd_pkg::ProdW-1:0]  r_mz_ax;
    logic signed [thd_pkg::ProdW-1:0]  r_my_az;
    logic signed [thd_pkg::ProdW-1:0]  r_mz_ay;
    logic                              r_d_vld;
    logic signed [thd_pkg::CrossW-1:0] r_xh;
    logic signed [thd_pkg::CrossW-1:0] r_yh;
    logic signed [thd_pkg::CrossW-1:0] n_xh;
    logic signed [thd_pkg::CrossW-1:0] n_yh;

    // valid bits of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
            r_d_vld <= r_p_vld;
        end
    end

    // stage 1: the four products
    always_ff @(posedge i_clk) begin
        r_mx_az <= i_mag_x * i_acc_z;
        r_mz_ax <= i_mag_z * i_acc_x;
        r_my_az <= i_mag_y * i_acc_z;
        r_mz_ay <= i_mag_z * i_acc_y;
    end

    // stage 2: cross differences, one bit wider than the products
    always_comb begin
        n_xh = {r_mx_az[thd_pkg::ProdW-1], r_mx_az} - {r_mz_ax[thd_pkg::ProdW-1], r_mz_ax};
        n_yh = {r_my_az[thd_pkg::ProdW-1], r_my_az} - {r_mz_ay[thd_pkg::ProdW-1], r_mz_ay};
    end

    always_ff @(posedge i_clk) begin
        r_xh <= n_xh;
        r_yh <= n_yh;
    end

    assign o_vld = r_d_vld;
    assign o_xh  = r_xh;
    assign o_yh  = r_yh;

endmodule

// ===== design/thd_norm.sv =====
// thd_norm: scales (xh, yh) by a power of two until the larger magnitude reaches 2^56,
// then folds the left half-plane onto the right; depends on thd_pkg

module thd_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  logic signed [thd_pkg::CrossW-1:0]  i_xh,
    input  logic signed [thd_pkg::CrossW-1:0]  i_yh,
    output thd_pkg::t_ctl                      o_ctl,
    output logic signed [thd_pkg::CordW-1:0]   o_x,
    output logic signed [thd_pkg::CordW-1:0]   o_y,
    output logic signed [thd_pkg::AngW-1:0]    o_z
);

    typedef struct packed {
        logic [thd_pkg::MagW-1:0]         o;
        logic signed [thd_pkg::NormW-1:0] x;
        logic signed [thd_pkg::NormW-1:0] y;
    } t_nv;

    // shift by k when the or-ed magnitude stays below 2^57 afterwards
    function automatic t_nv nstep(input t_nv v, input int unsigned k);
        t_nv r;
        r = v;
        if ((v.o >> (thd_pkg::MagW - k)) == '0) begin
            r.o = v.o << k;
            r.x = v.x << k;
            r.y = v.y << k;
        end
        return r;
    endfunction

    logic [thd_pkg::CrossW-1:0]        ax;
    logic [thd_pkg::CrossW-1:0]        ay;
    logic [thd_pkg::CrossW-1:0]        aor;
    t_nv                               v0;
    t_nv                               n_a;
    t_nv                               n_b;
    t_nv                               n_c;
    t_nv                               r_a;
    t_nv                               r_b;
    t_nv                               r_c;
    thd_pkg::t_ctl                     r_a_ctl;
    thd_pkg::t_ctl                     r_b_ctl;
    thd_pkg::t_ctl                     r_c_ctl;
    thd_pkg::t_ctl                     r_d_ctl;
    logic                              neg;
    logic signed [thd_pkg::CordW-1:0]  cx;
    logic signed [thd_pkg::CordW-1:0]  cy;
    logic signed [thd_pkg::CordW-1:0]  n_x;
    logic signed [thd_pkg::CordW-1:0]  n_y;
    logic signed [thd_pkg::AngW-1:0]   n_z;
    logic signed [thd_pkg::CordW-1:0]  r_x;
    logic signed [thd_pkg::CordW-1:0]  r_y;
    logic signed [thd_pkg::AngW-1:0]   r_z;

    // stage a: magnitudes, zero test, shifts by 32 and 16
    always_comb begin
        ax   = i_xh[thd_pkg::CrossW-1] ? (thd_pkg::CrossW'(0) - i_xh) : i_xh;
        ay   = i_yh[thd_pkg::CrossW-1] ? (thd_pkg::CrossW'(0) - i_yh) : i_yh;
        aor  = ax | ay;
        v0.o = {{(thd_pkg::MagW - thd_pkg::CrossW){1'b0}}, aor};
        v0.x = {{(thd_pkg::NormW - thd_pkg::CrossW){i_xh[thd_pkg::CrossW-1]}}, i_xh};
        v0.y = {{(thd_pkg::NormW - thd_pkg::CrossW){i_yh[thd_pkg::CrossW-1]}}, i_yh};
        n_a  = nstep(nstep(v0, 32), 16);
    end

    // stages b and c: shifts by 8, 4, then 2, 1
    always_comb begin
        n_b = nstep(nstep(r_a, 8), 4);
        n_c = nstep(nstep(r_b, 2), 1);
    end

    // stage d: fold the left half-plane, start the angle at a half turn there
    always_comb begin
        neg = r_c.x[thd_pkg::NormW-1];
        cx  = {{(thd_pkg::CordW - thd_pkg::NormW){r_c.x[thd_pkg::NormW-1]}}, r_c.x};
        cy  = {{(thd_pkg::CordW - thd_pkg::NormW){r_c.y[thd_pkg::NormW-1]}}, r_c.y};
        n_x = neg ? -cx : cx;
        n_y = neg ? -cy : cy;
        n_z = neg ? thd_pkg::HalfTurnNd : '0;
    end

    // valid and zero flags travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
            r_d_ctl <= '0;
        end else begin
            r_a_ctl <= '{vld: i_vld, zero: (aor == '0)};
            r_b_ctl <= r_a_ctl;
            r_c_ctl <= r_b_ctl;
            r_d_ctl <= r_c_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_d_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ===== design/thd_cordic.sv =====
// thd_cordic: 32 vectoring rotation stages, one iteration per register stage
// depends on thd_pkg (widths and the arctangent table)

module thd_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  thd_pkg::t_ctl                      i_ctl,
    input  logic signed [thd_pkg::CordW-1:0]   i_x,
    input  logic signed [thd_pkg::CordW-1:0]   i_y,
    input  logic signed [thd_pkg::AngW-1:0]    i_z,
    output thd_pkg::t_ctl                      o_ctl,
    output logic signed [thd_pkg::AngW-1:0]    o_z
);

    thd_pkg::t_ctl                     r_ctl [thd_pkg::Steps];
    logic signed [thd_pkg::CordW-1:0]  r_x   [thd_pkg::Steps];
    logic signed [thd_pkg::CordW-1:0]  r_y   [thd_pkg::Steps];
    logic signed [thd_pkg::AngW-1:0]   r_z   [thd_pkg::Steps];

    for (genvar i = 0; i < thd_pkg::Steps; i++) begin : g_stage
        localparam logic signed [thd_pkg::AngW-1:0] Tab =
            $signed({{(thd_pkg::AngW - thd_pkg::TabW){1'b0}}, thd_pkg::atan_nd(i)});

        thd_pkg::t_ctl                    cc;
        logic signed [thd_pkg::CordW-1:0] cx;
        logic signed [thd_pkg::CordW-1:0] cy;
        logic signed [thd_pkg::AngW-1:0]  cz;
        logic signed [thd_pkg::CordW-1:0] n_x;
        logic signed [thd_pkg::CordW-1:0] n_y;
        logic signed [thd_pkg::AngW-1:0]  n_z;

        // stage input: module port for the first, previous register otherwise
        if (i == 0) begin : g_first
            assign cc = i_ctl;
            assign cx = i_x;
            assign cy = i_y;
            assign cz = i_z;
        end else begin : g_next
            assign cc = r_ctl[i-1];
            assign cx = r_x[i-1];
            assign cy = r_y[i-1];
            assign cz = r_z[i-1];
        end

        // rotate toward the x axis by atan(2^-i)
        always_comb begin
            if (!cy[thd_pkg::CordW-1]) begin
                n_x = cx + (cy >>> i);
                n_y = cy - (cx >>> i);
                n_z = cz + Tab;
            end else begin
                n_x = cx - (cy >>> i);
                n_y = cy + (cx >>> i);
                n_z = cz - Tab;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[i] <= '0;
            end else begin
                r_ctl[i] <= cc;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[i] <= n_x;
            r_y[i] <= n_y;
            r_z[i] <= n_z;
        end
    end

    assign o_ctl = r_ctl[thd_pkg::Steps-1];
    assign o_z   = r_z[thd_pkg::Steps-1];

endmodule

// ===== design/thd_out.sv =====
// thd_out: wraps the angle into one turn, rounds to hundredths of a degree by a
// reciprocal multiply and folds a full turn to zero; depends on thd_pkg

module thd_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  thd_pkg::t_ctl                     i_ctl,
    input  logic signed [thd_pkg::AngW-1:0]   i_z,
    output logic                              o_valid,
    output logic [thd_pkg::HeadW-1:0]         o_heading
);

    logic [thd_pkg::AngW-1:0]     n_sum;
    logic [thd_pkg::QuoInW-1:0]   r_n;
    logic [thd_pkg::ProdOutW-1:0] r_prod;
    logic [thd_pkg::HeadW-1:0]    quo;
    logic [thd_pkg::HeadW-1:0]    n_head;
    logic [thd_pkg::HeadW-1:0]    r_head;
    thd_pkg::t_ctl                r_s1_ctl;
    thd_pkg::t_ctl                r_s2_ctl;
    logic                         r_vld;

    // stage 1: wrap a negative angle by a full turn and add half a centidegree
    always_comb begin
        n_sum = $unsigned(i_z) + (i_z[thd_pkg::AngW-1] ? thd_pkg::WrapRound : thd_pkg::RoundOnly);
    end

    // stage 3: quotient, a full turn and a zero input vector both read as zero
    always_comb begin
        quo = r_prod[thd_pkg::RecipSh +: thd_pkg::HeadW];
        if (r_s2_ctl.zero) begin
            n_head = '0;
        end else if (quo >= thd_pkg::FullTurnCd) begin
            n_head = quo - thd_pkg::FullTurnCd;
        end else begin
            n_head = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_vld    <= 1'b0;
        end else begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_vld    <= r_s2_ctl.vld;
        end
    end

    // stage 2: multiply by the reciprocal of 78125
    always_ff @(posedge i_clk) begin
        r_n    <= n_sum[thd_pkg::ScaleDrop +: thd_pkg::QuoInW];
        r_prod <= r_n * thd_pkg::RecipM;
        r_head <= n_head;
    end

    assign o_valid   = r_vld;
    assign o_heading = r_head;

endmodule

// ===== design/tilt_compensated_heading.sv =====
// tilt_compensated_heading: top level of the compass heading pipeline
// depends on thd_pkg, thd_front, thd_norm, thd_cordic, thd_out
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------------
//  sample in | i_start / o_busy     | i_mag_x, i_mag_y, i_mag_z, i_acc_x..i_acc_z
//  heading   | o_valid (one cycle)  | o_heading_centideg, 0..35999
//
//  a transaction is taken on every edge with i_start high and o_busy low, one per cycle
//  each result passes through 2 cross product stages, 4 normalization stages, 32 rotation
//  stages and 3 output stages
//  o_busy is high during reset and for the cycle after it, never later; results leave in order
//  the receiver cannot stall, so nothing inside the pipeline ever waits
//  reset clears all valid bits, so transactions in flight at reset are dropped

module tilt_compensated_heading (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [thd_pkg::InW-1:0]    i_mag_x,
    input  logic signed [thd_pkg::InW-1:0]    i_mag_y,
    input  logic signed [thd_pkg::InW-1:0]    i_mag_z,
    input  logic signed [thd_pkg::InW-1:0]    i_acc_x,
    input  logic signed [thd_pkg::InW-1:0]    i_acc_y,
    input  logic signed [thd_pkg::InW-1:0]    i_acc_z,
    output logic                              o_valid,
    output logic [thd_pkg::HeadW-1:0]         o_heading_centideg
);

    logic                              r_busy;
    logic                              accept;
    logic                              f_vld;
    logic signed [thd_pkg::CrossW-1:0] f_xh;
    logic signed [thd_pkg::CrossW-1:0] f_yh;
    thd_pkg::t_ctl                     nm_ctl;
    logic signed [thd_pkg::CordW-1:0]  nm_x;
    logic signed [thd_pkg::CordW-1:0]  nm_y;
    logic signed [thd_pkg::AngW-1:0]   nm_z;
    thd_pkg::t_ctl                     cd_ctl;
    logic signed [thd_pkg::AngW-1:0]   cd_z;

    // busy only during reset and right after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign accept = i_start & ~r_busy;

    thd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_mag_x (i_mag_x),
        .i_mag_y (i_mag_y),
        .i_mag_z (i_mag_z),
        .i_acc_x (i_acc_x),
        .i_acc_y (i_acc_y),
        .i_acc_z (i_acc_z),
        .o_vld   (f_vld),
        .o_xh    (f_xh),
        .o_yh    (f_yh)
    );

    thd_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_xh    (f_xh),
        .i_yh    (f_yh),
        .o_ctl   (nm_ctl),
        .o_x     (nm_x),
        .o_y     (nm_y),
        .o_z     (nm_z)
    );

    thd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (nm_ctl),
        .i_x     (nm_x),
        .i_y     (nm_y),
        .i_z     (nm_z),
        .o_ctl   (cd_ctl),
        .o_z     (cd_z)
    );

    thd_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (cd_ctl),
        .i_z       (cd_z),
        .o_valid   (o_valid),
        .o_heading (o_heading_centideg)
    );

endmodule

// ===== design/thd_checker.sv =====
// thd_checker: port-level checks of tilt_compensated_heading, attached by bind
// depends on thd_pkg (pipeline latency, heading range)

module thd_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       o_busy,
    input  logic                       o_valid,
    input  logic [thd_pkg::HeadW-1:0]  o_heading_centideg
);

    // every heading lies inside one turn
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading_centideg < thd_pkg::FullTurnCd))
        else $error("heading out of range");

    // each transaction gives its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(thd_pkg::Latency) o_valid)
        else $error("result missing after fixed latency");

    // after a reset edge the block is busy and shows no result
    a_post_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (o_busy && !o_valid))
        else $error("state after reset wrong");

    // once free, busy does not return without reset
    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |=> !o_busy)
        else $error("busy rose outside reset");

endmodule

bind tilt_compensated_heading thd_checker u_thd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_start            (i_start),
    .o_busy             (o_busy),
    .o_valid            (o_valid),
    .o_heading_centideg (o_heading_centideg)
);
